// ----- hdl/sorted_matrix_staircase_search_core_macros.svh -----
// ---------------------------------------------------------------------------
// Assertion macros for the staircase search core
// Concurrent checks, clocked on clk and disabled while rst_n is low.
// ---------------------------------------------------------------------------
`ifndef SORTED_MATRIX_STAIRCASE_SEARCH_CORE_MACROS_SVH
`define SORTED_MATRIX_STAIRCASE_SEARCH_CORE_MACROS_SVH

`ifndef ASSERT_OFF

`define SMSS_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("staircase search check failed");

`define SMSS_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("staircase search check failed");

`define SMSS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("staircase search check failed");

`else

`define SMSS_ASSERT(lbl, prop)

`define SMSS_ASSERT_IMPL(lbl, ante, cons)

`define SMSS_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

// ----- hdl/smss_pkg.sv -----
// ---------------------------------------------------------------------------
// smss_pkg
// Shared types and constants of the staircase search core.
// ---------------------------------------------------------------------------
package smss_pkg;

    localparam int DATA_W = 32;
    localparam int RIU_W  = 5;

    localparam logic CMD_WRITE  = 1'b0;
    localparam logic CMD_SEARCH = 1'b1;

    typedef struct packed {
        logic                     go;
        logic [RIU_W-1:0]         rows;
        logic signed [DATA_W-1:0] key;
    } smss_launch_t;

    typedef struct packed {
        logic strobe;
        logic found;
    } smss_result_t;

endpackage

// ----- hdl/smss_ram.sv -----
// ---------------------------------------------------------------------------
// smss_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ---------------------------------------------------------------------------
module smss_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                                   clk,
    input  logic                                   wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                       wr_data,
    input  logic                                   rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                       rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- hdl/smss_walk.sv -----
// ---------------------------------------------------------------------------
// smss_walk
// Staircase walk sequencer: one matrix read per step, compare, step down or left.
// ---------------------------------------------------------------------------
`include "sorted_matrix_staircase_search_core_macros.svh"

module smss_walk #(
    parameter int ROWS = 16,
    parameter int COLS = 4
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  smss_pkg::smss_launch_t                 launch,
    output logic                                   rd_en,
    output logic [((ROWS > 1) ? $clog2(ROWS) : 1) + ((COLS > 1) ? $clog2(COLS) : 1)-1:0]
                                                   rd_addr,
    input  logic signed [smss_pkg::DATA_W-1:0]     rd_data,
    output logic                                   busy,
    output smss_pkg::smss_result_t                 result
);
    import smss_pkg::*;

    localparam int RW  = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int CW  = (COLS > 1) ? $clog2(COLS) : 1;
    localparam int CLW = $clog2(COLS + 1);
    localparam logic [CLW-1:0] COLS_INIT = CLW'(COLS);
    localparam logic [CLW-1:0] ONE_COL   = CLW'(1);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_WALK = 2'b10
    } walk_state_t;

    walk_state_t              state_reg, state_next;
    logic [RIU_W-1:0]         row_reg, row_next;
    logic [RIU_W-1:0]         rows_reg, rows_next;
    logic [CLW-1:0]           cols_left_reg, cols_left_next;
    logic signed [DATA_W-1:0] key_reg, key_next;
    logic                     strobe_reg, strobe_next;
    logic                     found_reg, found_next;
    logic [RIU_W-1:0]         row_inc;
    logic [CLW-1:0]           col_cur;
    logic                     hit;
    logic                     less;

    assign row_inc = row_reg + RIU_W'(1);
    assign hit     = (rd_data == key_reg);
    assign less    = (rd_data < key_reg);

    always_comb
    begin
        state_next     = state_reg;
        row_next       = row_reg;
        rows_next      = rows_reg;
        cols_left_next = cols_left_reg;
        key_next       = key_reg;
        strobe_next    = 1'b0;
        found_next     = found_reg;
        rd_en          = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (launch.go)
                begin
                    key_next  = launch.key;
                    rows_next = launch.rows;
                    if (launch.rows == '0)
                    begin
                        strobe_next = 1'b1;
                        found_next  = 1'b0;
                    end
                    else
                    begin
                        row_next       = '0;
                        cols_left_next = COLS_INIT;
                        rd_en          = 1'b1;
                        state_next     = ST_WALK;
                    end
                end
            end
            ST_WALK:
            begin
                if (hit)
                begin
                    strobe_next = 1'b1;
                    found_next  = 1'b1;
                    state_next  = ST_IDLE;
                end
                else if (less)
                begin
                    if (row_inc >= rows_reg)
                    begin
                        strobe_next = 1'b1;
                        found_next  = 1'b0;
                        state_next  = ST_IDLE;
                    end
                    else
                    begin
                        row_next = row_inc;
                        rd_en    = 1'b1;
                    end
                end
                else
                begin
                    if (cols_left_reg == ONE_COL)
                    begin
                        strobe_next = 1'b1;
                        found_next  = 1'b0;
                        state_next  = ST_IDLE;
                    end
                    else
                    begin
                        cols_left_next = cols_left_reg - ONE_COL;
                        rd_en          = 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign col_cur = cols_left_next - ONE_COL;
    assign rd_addr = {RW'(row_next), CW'(col_cur)};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            row_reg       <= '0;
            rows_reg      <= '0;
            cols_left_reg <= COLS_INIT;
            strobe_reg    <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            row_reg       <= row_next;
            rows_reg      <= rows_next;
            cols_left_reg <= cols_left_next;
            strobe_reg    <= strobe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg   <= key_next;
        found_reg <= found_next;
    end

    assign busy          = (state_reg != ST_IDLE);
    assign result.strobe = strobe_reg;
    assign result.found  = found_reg;

    `SMSS_ASSERT_IMPL(a_result_source, strobe_reg,
        $past(state_reg == ST_WALK) || $past(launch.go && state_reg == ST_IDLE))
    `SMSS_ASSERT_IMPL(a_row_in_range, state_reg == ST_WALK, row_reg < rows_reg)
    `SMSS_ASSERT_IMPL(a_col_in_range, state_reg == ST_WALK,
        cols_left_reg != '0 && cols_left_reg <= COLS_INIT)
    `SMSS_ASSERT_NEXT(a_hit_reports, state_reg == ST_WALK && hit,
        strobe_reg && found_reg && state_reg == ST_IDLE)

endmodule

// ----- hdl/sorted_matrix_staircase_search_core.sv -----
// ---------------------------------------------------------------------------
// sorted_matrix_staircase_search_core
// Sorted matrix store with staircase key search from the top-right entry.
// ---------------------------------------------------------------------------
//  channel   handshake                 payload
//  command   start, busy               cmd, row, col, entry_value, search_key
//  result    done (one-cycle strobe)   found
//  config    cfg_valid, cfg_ready      cfg_data (rows in use)
//
//  A write beat never raises busy.
//  A search beat reads one matrix entry per cycle from the single RAM read port:
//  at most rows_in_use + COLS - 1 steps, done in the cycle after the last step.
//  With rows_in_use at zero, done follows the search beat at once with found low.
//  Reset clears control state only; matrix entries hold garbage until written.
//  done is not back-pressured.
// ---------------------------------------------------------------------------
module sorted_matrix_staircase_search_core #(
    parameter int ROWS = 16,
    parameter int COLS = 4
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic                                cmd,
    input  logic [3:0]                          row,
    input  logic [1:0]                          col,
    input  logic signed [smss_pkg::DATA_W-1:0]  entry_value,
    input  logic signed [smss_pkg::DATA_W-1:0]  search_key,
    output logic                                done,
    output logic                                found,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [smss_pkg::RIU_W-1:0]          cfg_data
);
    import smss_pkg::*;

    localparam int RW    = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int CW    = (COLS > 1) ? $clog2(COLS) : 1;
    localparam int DEPTH = 2 ** (RW + CW);
    localparam logic [RIU_W-1:0] RIU_RESET = RIU_W'((ROWS < 16) ? ROWS : 16);

    logic [RIU_W-1:0]     riu_reg, riu_next;
    logic                 accept;
    logic                 wr_en;
    logic [RW+CW-1:0]     wr_addr;
    logic                 rd_en;
    logic [RW+CW-1:0]     rd_addr;
    logic [DATA_W-1:0]    rd_data;
    smss_launch_t         launch;
    smss_result_t         result;

    assign cfg_ready = 1'b1;
    assign riu_next  = (int'(cfg_data) > ROWS) ? RIU_W'(ROWS) : cfg_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            riu_reg <= RIU_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            riu_reg <= riu_next;
        end
    end

    // drop writes outside the matrix
    assign accept  = start && !busy;
    assign wr_en   = accept && (cmd == CMD_WRITE) && (int'(row) < ROWS) && (int'(col) < COLS);
    assign wr_addr = {RW'(row), CW'(col)};

    assign launch.go   = accept && (cmd == CMD_SEARCH);
    assign launch.rows = riu_reg;
    assign launch.key  = search_key;

    smss_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DEPTH)
    ) u_matrix_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (entry_value),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    smss_walk #(
        .ROWS (ROWS),
        .COLS (COLS)
    ) u_walk (
        .clk     (clk),
        .rst_n   (rst_n),
        .launch  (launch),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .busy    (busy),
        .result  (result)
    );

    assign done  = result.strobe;
    assign found = result.found;

endmodule

// ----- tb/sorted_matrix_staircase_search_core_tb.sv -----
// ---------------------------------------------------------------------------
// sorted_matrix_staircase_search_core_tb
// Self-checking bench for the staircase search core. A short table of
// directed beats covers the empty search, value extremes and small row
// counts. Randomised phases follow. Each phase sets the row count, loads a
// sorted matrix and runs mostly hit and near-miss searches, with some stray
// writes mixed in. Every done strobe is checked against the table's expected
// result or a local model of the walk.
// ---------------------------------------------------------------------------
module sorted_matrix_staircase_search_core_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import smss_pkg::*;

    localparam int ROWS         = 16;
    localparam int COLS         = 4;
    localparam int ITEMS_TARGET = 1300;

    localparam logic signed [DATA_W-1:0] KEY_MIN = 32'sh8000_0000;
    localparam logic signed [DATA_W-1:0] KEY_MAX = 32'sh7fff_ffff;

    typedef enum logic [1:0] {
        STEP_CFG,
        STEP_WRITE,
        STEP_SEARCH
    } step_kind_t;

    typedef struct packed {
        step_kind_t               kind;
        logic [3:0]               row;
        logic [1:0]               col;
        logic signed [DATA_W-1:0] value;
        logic signed [DATA_W-1:0] key;
        logic                     typed;
        logic                     typed_found;
    } dir_step_t;

    localparam dir_step_t DIR_TABLE [23] = '{
        '{STEP_CFG,    4'd0,  2'd0, 32'sd0,    32'sd0,    1'b0, 1'b0},
        '{STEP_SEARCH, 4'd0,  2'd0, 32'sd0,    32'sd0,    1'b1, 1'b0},
        '{STEP_SEARCH, 4'd0,  2'd0, 32'sd0,    KEY_MAX,   1'b1, 1'b0},
        '{STEP_CFG,    4'd0,  2'd0, 32'sd1,    32'sd0,    1'b0, 1'b0},
        '{STEP_WRITE,  4'd0,  2'd0, KEY_MIN,   32'sd0,    1'b0, 1'b0},
        '{STEP_WRITE,  4'd0,  2'd1, -32'sd1,   32'sd0,    1'b0, 1'b0},
        '{STEP_WRITE,  4'd0,  2'd2, 32'sd0,    32'sd0,    1'b0, 1'b0},
        '{STEP_WRITE,  4'd0,  2'd3, KEY_MAX,   32'sd0,    1'b0, 1'b0},
        '{STEP_WRITE,  4'd15, 2'd3, KEY_MAX,   32'sd0,    1'b0, 1'b0},
        '{STEP_SEARCH, 4'd0,  2'd0, 32'sd0,    KEY_MAX,   1'b1, 1'b1},
        '{STEP_SEARCH, 4'd0,  2'd0, 32'sd0,    KEY_MIN,   1'b1, 1'b1},
        '{STEP_SEARCH, 4'd0,  2'd0, 32'sd0,    32'sd5,    1'b0, 1'b0},
        '{STEP_SEARCH, 4'd0,  2'd0, 32'sd0,    -32'sd5,   1'b0, 1'b0},
        '{STEP_SEARCH, 4'd0,  2'd0, 32'sd0,    32'sd0,    1'b0, 1'b0},
        '{STEP_CFG,    4'd0,  2'd0, 32'sd2,    32'sd0,    1'b0, 1'b0},
        '{STEP_WRITE,  4'd1,  2'd0, -32'sd100, 32'sd0,    1'b0, 1'b0},
        '{STEP_WRITE,  4'd1,  2'd1, 32'sd0,    32'sd0,    1'b0, 1'b0},
        '{STEP_WRITE,  4'd1,  2'd2, 32'sd7,    32'sd0,    1'b0, 1'b0},
        '{STEP_WRITE,  4'd1,  2'd3, KEY_MAX,   32'sd0,    1'b0, 1'b0},
        '{STEP_SEARCH, 4'd0,  2'd0, 32'sd0,    32'sd7,    1'b0, 1'b0},
        '{STEP_SEARCH, 4'd0,  2'd0, 32'sd0,    32'sd6,    1'b0, 1'b0},
        '{STEP_SEARCH, 4'd0,  2'd0, 32'sd0,    -32'sd100, 1'b0, 1'b0},
        '{STEP_SEARCH, 4'd0,  2'd0, 32'sd0,    KEY_MIN,   1'b1, 1'b1}
    };

    localparam int FORCED_ROWS [5] = '{16, 31, 0, 17, 1};

    logic                     clk = 1'b0;
    logic                     rst_n;
    logic                     start;
    logic                     busy;
    logic                     cmd;
    logic [3:0]               row;
    logic [1:0]               col;
    logic signed [DATA_W-1:0] entry_value;
    logic signed [DATA_W-1:0] search_key;
    logic                     done;
    logic                     found;
    logic                     cfg_valid;
    logic                     cfg_ready;
    logic [RIU_W-1:0]         cfg_data;

    logic signed [DATA_W-1:0] matrix_copy [ROWS*COLS];
    int                       rows_live;
    bit                       found_due [$];
    bit                       want_found;

    int errors;
    int beats_sent;
    int searches_sent;
    int results_seen;
    int hits_seen;
    int row_settings;
    int burst_left;

    sorted_matrix_staircase_search_core #(
        .ROWS (ROWS),
        .COLS (COLS)
    ) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .cmd         (cmd),
        .row         (row),
        .col         (col),
        .entry_value (entry_value),
        .search_key  (search_key),
        .done        (done),
        .found       (found),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic bit staircase_hit(input logic signed [DATA_W-1:0] key);
        int r;
        int c;
        bit hit;
        r   = 0;
        c   = COLS - 1;
        hit = 1'b0;
        while (!hit && r < rows_live && c >= 0)
        begin
            if (matrix_copy[r*COLS+c] == key)
                hit = 1'b1;
            else if (matrix_copy[r*COLS+c] < key)
                r++;
            else
                c--;
        end
        return hit;
    endfunction

    // wait until every search has answered and the core is quiet
    task automatic drain_results();
        start <= 1'b0;
        while (found_due.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    task automatic write_rows_in_use(input logic [RIU_W-1:0] v);
        drain_results();
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        rows_live = (int'(v) > ROWS) ? ROWS : int'(v);
        row_settings++;
    endtask

    task automatic drive_beat(input logic c, input logic [3:0] r, input logic [1:0] k,
                              input logic signed [DATA_W-1:0] v,
                              input logic signed [DATA_W-1:0] key,
                              input bit typed, input bit typed_found);
        start       <= 1'b1;
        cmd         <= c;
        row         <= r;
        col         <= k;
        entry_value <= v;
        search_key  <= key;
        do
            @(posedge clk);
        while (busy);
        beats_sent++;
        if (c == CMD_WRITE)
            matrix_copy[int'(r)*COLS+int'(k)] = v;
        else
        begin
            found_due.push_back(typed ? typed_found : staircase_hit(key));
            searches_sent++;
        end
        if (burst_left > 0)
            burst_left--;
        else
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 24)) @(posedge clk);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(0, 12);
        end
    endtask

    // load rows in use with a matrix sorted along rows and columns
    task automatic load_sorted_matrix(input int mode);
        longint grid [ROWS][COLS];
        longint base;
        longint lo;
        longint v;
        base = (mode == 2) ? longint'(KEY_MIN) : longint'($signed($urandom()));
        for (int r = 0; r < rows_live; r++)
            for (int c = 0; c < COLS; c++)
            begin
                lo = base;
                if (r > 0 && grid[r-1][c] > lo)
                    lo = grid[r-1][c];
                if (c > 0 && grid[r][c-1] > lo)
                    lo = grid[r][c-1];
                case (mode)
                    0:       v = lo + longint'($urandom_range(0, 3));
                    1:       v = lo + longint'($urandom_range(0, 1 << 24));
                    default: v = lo + longint'($urandom_range(0, 1 << 29));
                endcase
                if (v > longint'(KEY_MAX))
                    v = longint'(KEY_MAX);
                grid[r][c] = v;
                drive_beat(CMD_WRITE, r[3:0], c[1:0], v[DATA_W-1:0], $urandom(), 1'b0, 1'b0);
            end
    endtask

    task automatic search_or_stray();
        int                       pick;
        int                       idx;
        logic signed [DATA_W-1:0] key;
        pick = $urandom_range(0, 99);
        idx  = (rows_live > 0) ? $urandom_range(0, rows_live*COLS - 1) : 0;
        if (pick < 12)
            drive_beat(CMD_WRITE, 4'($urandom()), 2'($urandom()), $urandom(), $urandom(),
                       1'b0, 1'b0);
        else
        begin
            if (rows_live == 0 || pick >= 76)
                key = $urandom();
            else if (pick < 50)
                key = matrix_copy[idx];
            else if (pick < 68)
                key = matrix_copy[idx] + ((pick % 2) ? 32'sd1 : -32'sd1);
            else
                key = (pick % 2) ? KEY_MAX : KEY_MIN;
            drive_beat(CMD_SEARCH, 4'($urandom()), 2'($urandom()), $urandom(), key,
                       1'b0, 1'b0);
        end
        if ($urandom_range(0, 79) == 0)
            drain_results();
    endtask

    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            results_seen++;
            if (found === 1'b1)
                hits_seen++;
            if (found_due.size() == 0)
            begin
                $display("%0t: result with none pending, expected none, actual found=%0b",
                         $time, found);
                errors++;
            end
            else
            begin
                want_found = found_due.pop_front();
                if (found !== want_found)
                begin
                    $display("%0t: found mismatch, expected %0b, actual %0b",
                             $time, want_found, found);
                    errors++;
                end
            end
        end
    end

    initial
    begin
        int phase;
        rst_n       = 1'b0;
        start       = 1'b0;
        cmd         = CMD_WRITE;
        row         = '0;
        col         = '0;
        entry_value = '0;
        search_key  = '0;
        cfg_valid   = 1'b0;
        cfg_data    = '0;
        rows_live   = ROWS;
        burst_left  = 0;
        phase       = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (DIR_TABLE[i])
        begin
            case (DIR_TABLE[i].kind)
                STEP_CFG:
                    write_rows_in_use(DIR_TABLE[i].value[RIU_W-1:0]);
                STEP_WRITE:
                    drive_beat(CMD_WRITE, DIR_TABLE[i].row, DIR_TABLE[i].col,
                               DIR_TABLE[i].value, $urandom(), 1'b0, 1'b0);
                default:
                    drive_beat(CMD_SEARCH, 4'($urandom()), 2'($urandom()), $urandom(),
                               DIR_TABLE[i].key, DIR_TABLE[i].typed,
                               DIR_TABLE[i].typed_found);
            endcase
        end

        while (beats_sent < ITEMS_TARGET)
        begin
            if (phase < 5)
                write_rows_in_use(RIU_W'(FORCED_ROWS[phase]));
            else if ($urandom_range(0, 3) == 0)
                write_rows_in_use(RIU_W'(ROWS));
            else
                write_rows_in_use(RIU_W'($urandom_range(0, 31)));
            load_sorted_matrix($urandom_range(0, 2));
            repeat ($urandom_range(20, 60)) search_or_stray();
            phase++;
        end

        drain_results();
        repeat (40) @(posedge clk);
        $display("Sent %0d beats (%0d searches) over %0d row-count settings;",
                 beats_sent, searches_sent, row_settings);
        $display("checked %0d results, %0d of them hits, %0d errors.",
                 results_seen, hits_seen, errors);
        if (errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("Timed out waiting for the core.");
        $display("CHECK FAILED");
        $finish;
    end

endmodule

// ----- filelist.f -----
+incdir+hdl
hdl/smss_pkg.sv
hdl/smss_ram.sv
hdl/smss_walk.sv
hdl/sorted_matrix_staircase_search_core.sv
tb/sorted_matrix_staircase_search_core_tb.sv
